>>> rtl/core/tdfd_pkg.sv
// Shared constants, types and helpers for the toll display frame delimiter.
package tdfd_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 3;

    // Register index carried in paddr[2]
    localparam logic REG_MAX_FRAME_BYTES = 1'b0;

    localparam logic [BYTE_W-1:0] START_BYTE  = 8'h0A;
    localparam logic [BYTE_W-1:0] END_BYTE    = 8'h0D;
    localparam logic [BYTE_W-1:0] CMD_STATIC  = 8'h00;
    localparam logic [BYTE_W-1:0] CMD_SCROLL  = 8'h01;
    localparam logic [BYTE_W-1:0] CMD_BRIGHT  = 8'h40;
    localparam logic [BYTE_W-1:0] CMD_LAMP_A  = 8'h36;
    localparam logic [BYTE_W-1:0] CMD_LAMP_B  = 8'h37;
    localparam logic [BYTE_W-1:0] CMD_LAMP_C  = 8'h38;
    localparam logic [BYTE_W-1:0] CMD_LAMP_D  = 8'h39;
    localparam logic [BYTE_W-1:0] CMD_BEAT    = 8'h50;
    localparam logic [BYTE_W-1:0] ROW_MAX     = 8'd6;
    localparam logic [BYTE_W-1:0] LIMIT_RESET = 8'd149;
    localparam logic [BYTE_W-1:0] LIMIT_FLOOR = 8'd3;

    localparam logic [BYTE_W-1:0] POS_CMD       = 8'd1;
    localparam logic [BYTE_W-1:0] POS_ROW       = 8'd2;
    localparam logic [BYTE_W-1:0] POS_BRIGHT_END = 8'd4;
    localparam logic [BYTE_W-1:0] SCAN_STATIC   = 8'd3;
    localparam logic [BYTE_W-1:0] SCAN_SCROLL   = 8'd6;

    localparam logic [BYTE_W-1:0] LEN_HUNT   = 8'd1;
    localparam logic [BYTE_W-1:0] LEN_CMD    = 8'd2;
    localparam logic [BYTE_W-1:0] LEN_LAMP   = 8'd3;
    localparam logic [BYTE_W-1:0] LEN_BRIGHT = 8'd5;

    localparam logic VERDICT_OK     = 1'b0;
    localparam logic VERDICT_REJECT = 1'b1;

    typedef struct packed {
        logic              valid;
        logic              verdict;
        logic [BYTE_W-1:0] length;
        logic [BYTE_W-1:0] command;
    } result_t;

    function automatic logic is_lamp(input logic [BYTE_W-1:0] c);
        return (c == CMD_LAMP_A) || (c == CMD_LAMP_B) || (c == CMD_LAMP_C) ||
               (c == CMD_LAMP_D) || (c == CMD_BEAT);
    endfunction

endpackage

>>> rtl/core/toll_display_frame_delimiter.sv
// Top level of the toll display frame delimiter.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------
//  rx      | in        | rx_valid / rx_stall  | rx_byte[7:0]
//  res     | out       | res_valid / res_stall| verdict, frame_length[7:0], command_code[7:0]
//  apb     | in        | psel/penable/pready  | paddr[2:0], pwdata/prdata[31:0]
//
// One byte is taken per cycle while rx_stall is low. A byte is first captured in the
// input register; its request, if it makes one, is then loaded into the result register,
// which drives res_valid. The frame position and command registers close the only loop
// and are updated when the held byte advances.
// Reset clears both, so the block hunts for a start byte; the limit resets to 149.
// A stall on the result side holds back rx only while the held byte would produce
// a request and the result register is still full.
module toll_display_frame_delimiter
    import tdfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Byte stream in
    input  logic                  rx_valid,
    output logic                  rx_stall,
    input  logic [BYTE_W-1:0]     rx_byte,
    // Verdict requests out
    output logic                  res_valid,
    input  logic                  res_stall,
    output logic                  verdict,
    output logic [BYTE_W-1:0]     frame_length,
    output logic [BYTE_W-1:0]     command_code,
    // Configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [BYTE_W-1:0] max_frame_bytes;
    logic              out_free;
    logic              advance;
    result_t           result;

    logic              res_valid_reg;
    logic              res_valid_next;
    logic              verdict_reg;
    logic [BYTE_W-1:0] length_reg;
    logic [BYTE_W-1:0] command_reg;
    logic              load;

    tdfd_cfg_regs u_cfg (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .max_frame_bytes (max_frame_bytes)
    );

    tdfd_parser u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .rx_valid        (rx_valid),
        .rx_stall        (rx_stall),
        .rx_byte         (rx_byte),
        .max_frame_bytes (max_frame_bytes),
        .out_free        (out_free),
        .advance         (advance),
        .result          (result)
    );

    // The result register is free when empty or being drained this cycle
    assign out_free = !res_valid_reg || !res_stall;
    assign load     = advance && result.valid;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (out_free)
        begin
            res_valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    // Hold the payload until the request is taken
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            verdict_reg <= result.verdict;
            length_reg  <= result.length;
            command_reg <= result.command;
        end
    end

    assign res_valid    = res_valid_reg;
    assign verdict      = verdict_reg;
    assign frame_length = length_reg;
    assign command_code = command_reg;

endmodule

>>> rtl/core/tdfd_cfg_regs.sv
// APB register file holding the display frame length limit.
module tdfd_cfg_regs
    import tdfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [BYTE_W-1:0]     max_frame_bytes
);

    logic [BYTE_W-1:0] limit_reg;
    logic [BYTE_W-1:0] limit_next;
    logic              hit;

    assign hit = (paddr[2] == REG_MAX_FRAME_BYTES);

    always_comb
    begin
        limit_next = limit_reg;
        if (psel && penable && pwrite && hit)
        begin
            limit_next = pwdata[BYTE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    assign pready          = 1'b1;
    assign prdata          = hit ? {{(APB_DATA_W-BYTE_W){1'b0}}, limit_reg} : '0;
    assign max_frame_bytes = limit_reg;

endmodule

>>> rtl/core/tdfd_parser.sv
// Input byte register, frame position tracking and per-byte verdict logic.
module tdfd_parser
    import tdfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rx_valid,
    output logic              rx_stall,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic [BYTE_W-1:0] max_frame_bytes,
    input  logic              out_free,
    output logic              advance,
    output result_t           result
);

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic [BYTE_W-1:0] pos_reg;
    logic [BYTE_W-1:0] pos_next;
    logic [BYTE_W-1:0] cmd_reg;
    logic [BYTE_W-1:0] cmd_next;

    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] limit;
    logic [BYTE_W-1:0] scan_start;
    logic [BYTE_W:0]   pos_inc;
    logic [BYTE_W-1:0] step_pos;
    logic [BYTE_W-1:0] step_cmd;
    result_t           res;

    assign b          = in_byte_reg;
    assign limit      = (max_frame_bytes < LIMIT_FLOOR) ? LIMIT_FLOOR : max_frame_bytes;
    assign scan_start = (cmd_reg == CMD_SCROLL) ? SCAN_SCROLL : SCAN_STATIC;
    assign pos_inc    = {1'b0, pos_reg} + {{BYTE_W{1'b0}}, 1'b1};

    // Decide the byte held in the input register against the frame state
    always_comb
    begin
        res.valid   = 1'b0;
        res.verdict = VERDICT_REJECT;
        res.length  = pos_inc[BYTE_W-1:0];
        res.command = cmd_reg;
        step_pos    = pos_inc[BYTE_W-1:0];
        step_cmd    = cmd_reg;
        if (pos_reg == '0)
        begin
            res.length  = LEN_HUNT;
            res.command = '0;
            res.valid   = (b != START_BYTE);
        end
        else if (pos_reg == POS_CMD)
        begin
            step_cmd    = b;
            res.length  = LEN_CMD;
            res.command = b;
            res.valid   = !(is_lamp(b) || (b == CMD_BRIGHT) ||
                            (b == CMD_STATIC) || (b == CMD_SCROLL));
        end
        else if (is_lamp(cmd_reg))
        begin
            res.valid   = 1'b1;
            res.length  = LEN_LAMP;
            res.verdict = (b == END_BYTE) ? VERDICT_OK : VERDICT_REJECT;
        end
        else if (cmd_reg == CMD_BRIGHT)
        begin
            res.length  = LEN_BRIGHT;
            res.verdict = (b == END_BYTE) ? VERDICT_OK : VERDICT_REJECT;
            res.valid   = !(pos_reg < POS_BRIGHT_END);
        end
        else
        begin
            if ((pos_reg == POS_ROW) && (b > ROW_MAX))
            begin
                res.valid  = 1'b1;
                res.length = LEN_LAMP;
            end
            else if ((pos_reg >= scan_start) && (b == END_BYTE))
            begin
                res.valid   = 1'b1;
                res.verdict = VERDICT_OK;
            end
            else if (pos_inc >= {1'b0, limit})
            begin
                res.valid = 1'b1;
            end
        end
    end

    // A byte that makes no result never waits on the result side
    assign advance  = in_valid_reg && (!res.valid || out_free);
    assign rx_stall = in_valid_reg && !advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        pos_next      = pos_reg;
        cmd_next      = cmd_reg;
        if (!rx_stall)
        begin
            in_valid_next = rx_valid;
        end
        if (advance)
        begin
            if (res.valid)
            begin
                pos_next = '0;
                cmd_next = '0;
            end
            else
            begin
                pos_next = step_pos;
                cmd_next = step_cmd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            pos_reg      <= '0;
            cmd_reg      <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            pos_reg      <= pos_next;
            cmd_reg      <= cmd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!rx_stall && rx_valid)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    // Only a byte actually held in the input register makes a request
    always_comb
    begin
        result       = res;
        result.valid = res.valid && in_valid_reg;
    end

endmodule

>>> rtl/core/tdfd_checker.sv
// Port-level assertions for the toll display frame delimiter, bound to the top level.
module tdfd_checker
    import tdfd_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              res_valid,
    input logic              res_stall,
    input logic              verdict,
    input logic [BYTE_W-1:0] frame_length,
    input logic [BYTE_W-1:0] command_code
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result request dropped while stalled");

    a_ok_min_len: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (verdict == VERDICT_OK) |-> frame_length >= LEN_LAMP)
        else $error("accepted frame shorter than three bytes");

    a_lamp_len: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (verdict == VERDICT_OK) &&
        ((command_code == CMD_LAMP_A) || (command_code == CMD_LAMP_B) ||
         (command_code == CMD_LAMP_C) || (command_code == CMD_LAMP_D) ||
         (command_code == CMD_BEAT))
        |-> frame_length == LEN_LAMP)
        else $error("lamp frame accepted with wrong length");

    a_bright_len: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (command_code == CMD_BRIGHT) |-> frame_length == LEN_BRIGHT ||
        frame_length == LEN_CMD)
        else $error("brightness frame verdict with wrong length");

endmodule

bind toll_display_frame_delimiter tdfd_checker u_tdfd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .verdict      (verdict),
    .frame_length (frame_length),
    .command_code (command_code)
);
